// File: hw/rtl/jqe_pkg.sv
// Package for the JPEG quality estimator: constants, controller state type,
// command and status structs, and the reciprocal table of the standard corner.
// Used by every module in hw/rtl; depends on nothing.
`default_nettype none

package jqe_pkg;

  localparam int RATIO_FRAC_BITS_DEF = 24;

  localparam int QV_W     = 16;
  localparam int IDX_W    = 6;
  localparam int QUAL_W   = 7;
  localparam int COUNT_W  = 5;
  localparam int DIV_W    = 18;  // quotient and divisor width of the shared divider

  localparam logic [QV_W-1:0]    QV_SKIP   = 16'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [DIV_W-1:0]   Q_LIMIT   = 18'd100;
  localparam logic [DIV_W-1:0]   DIV_NUM   = 18'd5000;
  localparam logic [7:0]         Q_OFFSET  = 8'd200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LASTADD,
    ST_SCALE,
    ST_BIAS,
    ST_DIV1S,
    ST_DIV1W,
    ST_QCHK,
    ST_DIV2S,
    ST_DIV2W
  } state_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_HALF,
    OUT_DIV
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     add;
    logic     scale;
    logic     bias;
    logic     div_start;
    logic     div_sel;    // 0: numerator over count, 1: constant over q
    logic     q_load;
    logic     emit;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic n_zero;
    logic q_gt;
    logic div_done;
  } status_t;

  // Rounded reciprocal of the standard luminance corner entry k, scaled by
  // 2^frac. Every divisor is a literal, so this folds to a constant table.
  function automatic logic [63:0] recip(input logic [3:0] k, input int frac);
    logic [63:0] one;
    logic [63:0] r;
    one = 64'd1 << frac;
    case (k)
      4'd0:    r = (one + 64'd8)  / 64'd16;
      4'd1:    r = (one + 64'd5)  / 64'd11;
      4'd2:    r = (one + 64'd5)  / 64'd10;
      4'd3:    r = (one + 64'd8)  / 64'd16;
      4'd4:    r = (one + 64'd6)  / 64'd12;
      4'd5:    r = (one + 64'd6)  / 64'd12;
      4'd6:    r = (one + 64'd7)  / 64'd14;
      4'd7:    r = (one + 64'd9)  / 64'd19;
      4'd8:    r = (one + 64'd7)  / 64'd14;
      4'd9:    r = (one + 64'd6)  / 64'd13;
      4'd10:   r = (one + 64'd8)  / 64'd16;
      4'd11:   r = (one + 64'd12) / 64'd24;
      4'd12:   r = (one + 64'd7)  / 64'd14;
      4'd13:   r = (one + 64'd8)  / 64'd17;
      4'd14:   r = (one + 64'd11) / 64'd22;
      default: r = (one + 64'd14) / 64'd29;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jqe_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on jqe_pkg for its width.
`default_nettype none

module jqe_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [jqe_pkg::DIV_W-1:0] dividend,
  input  wire logic [jqe_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic [jqe_pkg::DIV_W-1:0]     quotient
);

  localparam int W  = jqe_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic          run_r,  run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [W-1:0]  dvd_r,  dvd_nxt;
  logic [W-1:0]  dvs_r,  dvs_nxt;
  logic [W-1:0]  rem_r,  rem_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = rem_sh >= {1'b0, dvs_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(W - 1);
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // The dividend register fills with quotient bits from the bottom.
      rem_nxt = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

// File: hw/rtl/jqe_dp.sv
// Datapath of the JPEG quality estimator: item registers, ratio multiplier,
// saturating accumulators, numerator build, shared divider and result register.
// Depends on jqe_pkg and jqe_div.
`default_nettype none

module jqe_dp #(
  parameter int RATIO_FRAC_BITS = jqe_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire jqe_pkg::cmd_t                   cmd,
  output jqe_pkg::status_t                     status,
  input  wire logic [jqe_pkg::IDX_W-1:0]       entry_index,
  input  wire logic [jqe_pkg::QV_W-1:0]        quant_value,
  input  wire logic                            last_entry,
  output logic [jqe_pkg::QUAL_W-1:0]           quality
);

  localparam int F   = RATIO_FRAC_BITS;
  localparam int RW  = F - 3;       // reciprocals stay below 2^F / 8
  localparam int PW  = RW + 8;      // counted entries are below 255
  localparam int SW  = F + 10;
  localparam int NW  = F + 18;
  localparam int DW  = jqe_pkg::DIV_W;
  localparam int CNW = jqe_pkg::COUNT_W;

  logic [7:0]     qv_r,    qv_nxt;
  logic [3:0]     k_r,     k_nxt;
  logic           addok_r, addok_nxt;
  logic           cntok_r, cntok_nxt;
  logic           last_r,  last_nxt;
  logic [PW-1:0]  prod_r,  prod_nxt;
  logic           inc_r,   inc_nxt;
  logic [SW-1:0]  sum_r,   sum_nxt;
  logic [CNW-1:0] cnt_r,   cnt_nxt;
  logic [NW-1:0]  num_r,   num_nxt;
  logic [DW-1:0]  q_r,     q_nxt;
  logic [jqe_pkg::QUAL_W-1:0] qual_r, qual_nxt;

  logic [63:0]    recip_full;
  logic [RW-1:0]  recip_v;
  logic [SW:0]    sum_wide;
  logic [NW-1:0]  sum_ext;
  logic           in_corner;
  logic [DW-1:0]  div_dvd;
  logic [DW-1:0]  div_dvs;
  logic           div_done;
  logic [DW-1:0]  div_q;
  logic [7:0]     half_v;

  jqe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    // Row below 4 clears bit 5, column below 4 clears bit 2.
    in_corner  = !entry_index[5] && !entry_index[2];
    recip_full = jqe_pkg::recip(k_r, F);
    recip_v    = recip_full[RW-1:0];
    sum_wide   = {1'b0, sum_r} + {{(SW-PW+1){1'b0}}, prod_r};
    sum_ext    = {{(NW-SW){1'b0}}, sum_r};
    half_v     = (jqe_pkg::Q_OFFSET - q_r[7:0]) >> 1;

    div_dvd = cmd.div_sel ? jqe_pkg::DIV_NUM : num_r[NW-1:F];
    div_dvs = cmd.div_sel ? q_r : {{(DW-CNW){1'b0}}, cnt_r};

    qv_nxt    = qv_r;
    k_nxt     = k_r;
    addok_nxt = addok_r;
    cntok_nxt = cntok_r;
    last_nxt  = last_r;
    prod_nxt  = prod_r;
    inc_nxt   = inc_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    q_nxt     = q_r;
    qual_nxt  = qual_r;

    if (cmd.load) begin
      qv_nxt    = quant_value[7:0];
      k_nxt     = {entry_index[4:3], entry_index[1:0]};
      cntok_nxt = in_corner && (quant_value < jqe_pkg::QV_SKIP);
      addok_nxt = in_corner && (quant_value < jqe_pkg::QV_SKIP) && (quant_value > 16'd1);
      last_nxt  = last_entry;
    end
    if (cmd.mul) begin
      prod_nxt = addok_r ? PW'(qv_r * recip_v) : '0;
      inc_nxt  = cntok_r;
    end
    if (cmd.add) begin
      sum_nxt = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
      if (inc_r && cnt_r != jqe_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.scale) begin
      // Times 100 as 64 + 32 + 4.
      num_nxt = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);
    end
    if (cmd.bias) begin
      num_nxt = num_r + ({{(NW-CNW){1'b0}}, cnt_r} << (F - 1));
    end
    if (cmd.q_load) begin
      q_nxt = div_q;
    end
    if (cmd.emit) begin
      case (cmd.out_sel)
        jqe_pkg::OUT_HALF: qual_nxt = half_v[jqe_pkg::QUAL_W-1:0];
        jqe_pkg::OUT_DIV:  qual_nxt = div_q[jqe_pkg::QUAL_W-1:0];
        default:           qual_nxt = '0;
      endcase
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    qv_r    <= qv_nxt;
    k_r     <= k_nxt;
    addok_r <= addok_nxt;
    cntok_r <= cntok_nxt;
    last_r  <= last_nxt;
    prod_r  <= prod_nxt;
    inc_r   <= inc_nxt;
    num_r   <= num_nxt;
    q_r     <= q_nxt;
    qual_r  <= qual_nxt;
  end

  always_comb begin
    status.last     = last_r;
    status.n_zero   = (cnt_r == '0);
    status.q_gt     = (q_r > jqe_pkg::Q_LIMIT);
    status.div_done = div_done;
  end

  assign quality = qual_r;

endmodule

`default_nettype wire

// File: hw/rtl/jqe_ctrl.sv
// Controller of the JPEG quality estimator: sequences multiply, accumulate
// and the end-of-table estimate. Depends on jqe_pkg.
`default_nettype none

module jqe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      out_valid,
  output jqe_pkg::cmd_t             cmd,
  input  wire jqe_pkg::status_t     status
);

  jqe_pkg::state_t state_r, state_nxt;
  logic            pend_r,  pend_nxt;
  logic            oval_r,  oval_nxt;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = 1'b0;
    oval_nxt  = 1'b0;
    cmd       = '0;
    busy      = (state_r != jqe_pkg::ST_IDLE);

    case (state_r)
      jqe_pkg::ST_IDLE: begin
        // The previous word's sum update overlaps the next accept.
        cmd.add = pend_r;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = jqe_pkg::ST_MUL;
        end
      end
      jqe_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        if (status.last) begin
          state_nxt = jqe_pkg::ST_LASTADD;
        end else begin
          pend_nxt  = 1'b1;
          state_nxt = jqe_pkg::ST_IDLE;
        end
      end
      jqe_pkg::ST_LASTADD: begin
        cmd.add   = 1'b1;
        state_nxt = jqe_pkg::ST_SCALE;
      end
      jqe_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = jqe_pkg::ST_BIAS;
      end
      jqe_pkg::ST_BIAS: begin
        cmd.bias  = 1'b1;
        state_nxt = jqe_pkg::ST_DIV1S;
      end
      jqe_pkg::ST_DIV1S: begin
        cmd.div_start = 1'b1;
        state_nxt     = jqe_pkg::ST_DIV1W;
      end
      jqe_pkg::ST_DIV1W: begin
        if (status.div_done) begin
          cmd.q_load = 1'b1;
          state_nxt  = jqe_pkg::ST_QCHK;
        end
      end
      jqe_pkg::ST_QCHK: begin
        if (status.n_zero) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = jqe_pkg::OUT_ZERO;
          oval_nxt    = 1'b1;
          state_nxt   = jqe_pkg::ST_IDLE;
        end else if (status.q_gt) begin
          state_nxt = jqe_pkg::ST_DIV2S;
        end else begin
          cmd.emit    = 1'b1;
          cmd.out_sel = jqe_pkg::OUT_HALF;
          oval_nxt    = 1'b1;
          state_nxt   = jqe_pkg::ST_IDLE;
        end
      end
      jqe_pkg::ST_DIV2S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = jqe_pkg::ST_DIV2W;
      end
      jqe_pkg::ST_DIV2W: begin
        if (status.div_done) begin
          cmd.emit    = 1'b1;
          cmd.out_sel = jqe_pkg::OUT_DIV;
          oval_nxt    = 1'b1;
          state_nxt   = jqe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jqe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jqe_pkg::ST_IDLE;
      pend_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

endmodule

`default_nettype wire

// File: hw/rtl/jpeg_quality_estimator_unit.sv
// Top level of the JPEG quality estimator: controller plus datapath.
// Depends on jqe_pkg, jqe_ctrl, jqe_dp (and jqe_div below it).
//
// Usage: feed the 64 luminance quantization entries of one table, one word
// per accept (start high while busy is low), with in_entry_index, in_quant_value
// and in_last_entry. Only the 4x4 low-frequency corner contributes; entries of
// 255 or more are skipped.
// A word that is not last passes through the accept, then the ratio multiply;
// busy is high in the multiply cycle and the sum update overlaps the next
// accept. After the last word the estimate follows the last add, the scale,
// the bias and the first division; a second division follows when the rounded
// average exceeds 100. Each of the one or two divisions runs on the shared
// one-bit-per-cycle divider.
// The result shows on out_quality with out_valid high for one cycle; the
// receiver cannot stall, so it must take the word in that cycle.
// Emitting the result clears the accumulators for the next table.
// Reset (rst_n low, synchronous) returns to idle with empty accumulators.
`default_nettype none

module jpeg_quality_estimator_unit #(
  parameter int RATIO_FRAC_BITS = jqe_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [jqe_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [jqe_pkg::QV_W-1:0]    in_quant_value,
  input  wire logic                        in_last_entry,
  output logic                             out_valid,
  output logic [jqe_pkg::QUAL_W-1:0]       out_quality
);

  jqe_pkg::cmd_t    cmd;
  jqe_pkg::status_t status;

  jqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  jqe_dp #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .entry_index (in_entry_index),
    .quant_value (in_quant_value),
    .last_entry  (in_last_entry),
    .quality     (out_quality)
  );

endmodule

`default_nettype wire
